[design/lrgd_pkg.sv]
// Package for the linear regression gradient descent unit.
// Holds the fixed-point widths, configuration register indexes, defaults,
// the multiplier request and response structs, and saturation helpers.
package lrgd_pkg;

    localparam int MAX_SAMPLES_DEF  = 1024;
    localparam int MAX_FEATURES_DEF = 15;
    localparam int VALUE_BITS_DEF   = 16;

    localparam int W_BITS     = 48;
    localparam int Q_FRAC     = 24;
    localparam int ALPHA_BITS = 32;
    localparam int MB_BITS    = 33;
    localparam int PROD_BITS  = W_BITS + MB_BITS;
    localparam int P_BITS     = PROD_BITS + 1;
    localparam int IDX_BITS   = 4;
    localparam int ITER_BITS  = 16;
    localparam int FC_BITS    = 4;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FEATURE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ITERATION_COUNT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEARNING_RATE   = 2'd2;

    localparam logic [FC_BITS-1:0]    FC_RESET   = 4'd1;
    localparam logic [ITER_BITS-1:0]  ITER_RESET = 16'd1;
    localparam logic [ALPHA_BITS-1:0] LR_RESET   = 32'd42950;

    localparam logic signed [W_BITS-1:0] W_ONE = 48'sh000001000000;

    typedef struct packed {
        logic                      start;
        logic signed [W_BITS-1:0]  a;
        logic signed [MB_BITS-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                        done;
        logic signed [PROD_BITS-1:0] p;
    } t_mul_rsp;

    function automatic logic signed [P_BITS-1:0] ext_w(input logic signed [W_BITS-1:0] w);
        return {{(P_BITS-W_BITS){w[W_BITS-1]}}, w};
    endfunction

    function automatic logic signed [W_BITS-1:0] sat_w(input logic signed [P_BITS-1:0] v);
        logic signed [P_BITS-1:0] hi;
        logic signed [P_BITS-1:0] lo;
        hi = {{(P_BITS-W_BITS+1){1'b0}}, {(W_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return {1'b0, {(W_BITS-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(W_BITS-1){1'b0}}};
        end
        return v[W_BITS-1:0];
    endfunction

endpackage

[design/lrgd_sample_if.sv]
// Input channel of the gradient descent unit: one training value per word.
// Depends on nothing else.
interface lrgd_sample_if #(parameter int VALUE_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         end_of_set;

    modport source (output valid, output value, output end_of_set, input ready);
    modport sink (input valid, input value, input end_of_set, output ready);
endinterface

[design/lrgd_weight_if.sv]
// Output channel of the gradient descent unit: one trained weight per word.
// Depends on nothing else.
interface lrgd_weight_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] weight;
    logic [3:0]         weight_index;
    logic               last;

    modport source (output valid, output weight, output weight_index, output last,
                    input ready);
    modport sink (input valid, input weight, input weight_index, input last,
                  output ready);
endinterface

[design/linear_regression_gradient_descent_unit.sv]
// Top level of the batch gradient descent linear regression unit.
// Depends on lrgd_pkg, lrgd_sample_if, lrgd_weight_if, lrgd_ram and lrgd_mul.
//
// Usage: the input channel carries one integer per word: per sample the
// configured number of feature values, then the label, with end_of_set high on
// the final label. Loading takes one word per cycle. The final label starts
// training: all weights restart at 1.0 and the configured number of batch
// passes run, after which the output channel delivers one word per weight,
// bias first, with last on the final one; then loading starts again.
// Every multiply runs in one shared serial shift-add multiplier, which stops
// shifting once no significant bit of its second operand is left. A pass
// first forms every hypothesis, then the gradient and step of each weight.
// The input is not ready during training or while weights are delivered. A
// stalled receiver holds the current weight word in the output register. Reset
// returns to loading with an empty set and the register defaults; the sample
// stores need no clearing.
module linear_regression_gradient_descent_unit #(
    parameter int MAX_SAMPLES  = lrgd_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_FEATURES = lrgd_pkg::MAX_FEATURES_DEF,
    parameter int VALUE_BITS   = lrgd_pkg::VALUE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    lrgd_sample_if.sink                        i_sample,
    lrgd_weight_if.source                      o_weight,
    input  logic                               i_cfg_we,
    input  logic [lrgd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [lrgd_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    localparam int SAW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SCW    = $clog2(MAX_SAMPLES + 1);
    localparam int FDEPTH = MAX_SAMPLES * MAX_FEATURES;
    localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
    localparam int WIW    = $clog2(MAX_FEATURES + 1);
    localparam int KW     = $clog2(MAX_FEATURES + 2);
    localparam int WB     = lrgd_pkg::W_BITS;
    localparam int PB     = lrgd_pkg::P_BITS;
    localparam int MB     = lrgd_pkg::MB_BITS;
    localparam int SB     = lrgd_pkg::PROD_BITS - lrgd_pkg::ALPHA_BITS;

    typedef enum logic [3:0] {
        ST_LOAD, ST_H_J, ST_H_K, ST_H_RD, ST_H_MUL,
        ST_G_K, ST_G_J, ST_G_RD, ST_G_MUL, ST_G_STEP, ST_EMIT
    } t_state;

    t_state r_state;

    logic [lrgd_pkg::FC_BITS-1:0]    r_cfg_fc;
    logic [lrgd_pkg::ITER_BITS-1:0]  r_cfg_it;
    logic [lrgd_pkg::ALPHA_BITS-1:0] r_cfg_lr;

    logic [SCW-1:0]       r_cnt;
    logic [WIW-1:0]       r_pos;
    logic [FAW-1:0]       r_base;
    logic [FAW-1:0]       r_addr;
    logic [WIW-1:0]       r_fc;
    logic [SCW-1:0]       r_j;
    logic [KW-1:0]        r_k;
    logic [lrgd_pkg::ITER_BITS-1:0] r_iter;
    logic signed [WB-1:0] r_acc;
    logic signed [WB-1:0] r_g;
    logic signed [WB-1:0] r_w [MAX_FEATURES+1];

    logic                 r_ovalid;
    logic signed [WB-1:0] r_oweight;
    logic                 r_olast;

    lrgd_pkg::t_mul_req r_mreq;
    lrgd_pkg::t_mul_rsp mrsp;

    logic                         in_acc;
    logic signed [VALUE_BITS-1:0] v;
    logic [WIW-1:0]               fc_now;
    logic                         is_feat;
    logic                         room;
    logic                         out_acc;

    logic                         feat_we, lab_we, hyp_we, feat_re, samp_re, fill_re;
    logic [FAW-1:0]               feat_waddr;
    logic signed [VALUE_BITS-1:0] feat_q, lab_q;
    logic signed [WB-1:0]         hyp_q;
    logic [WIW-1:0]               fill_q;

    logic signed [VALUE_BITS-1:0] x_feat;
    logic signed [WB-1:0]         err;
    logic signed [WB-1:0]         prod_sat;
    logic signed [PB-1:0]         step_ext;
    logic signed [WB-1:0]         w_k;
    logic                         k_over;

    assign in_acc  = i_sample.valid && (r_state == ST_LOAD);
    assign v       = i_sample.value;
    assign fc_now  = (int'(r_cfg_fc) > MAX_FEATURES) ? WIW'(MAX_FEATURES) : WIW'(r_cfg_fc);
    assign is_feat = (r_pos < fc_now) && !i_sample.end_of_set;
    assign room    = r_cnt < SCW'(MAX_SAMPLES);
    assign out_acc = r_ovalid && o_weight.ready;

    assign feat_we    = in_acc && is_feat && room;
    assign lab_we     = in_acc && !is_feat && room;
    assign feat_waddr = r_base + FAW'(r_pos);
    assign k_over     = r_k > KW'(r_fc);
    assign hyp_we     = (r_state == ST_H_K) && k_over;
    assign feat_re    = ((r_state == ST_H_K) && !k_over) || (r_state == ST_G_J);
    assign samp_re    = (r_state == ST_G_J);
    assign fill_re    = (r_state == ST_H_J) || (r_state == ST_G_J);

    assign w_k      = r_w[r_k[WIW-1:0]];
    assign x_feat   = (r_k <= KW'(fill_q)) ? feat_q : '0;
    assign err      = lrgd_pkg::sat_w(({{(PB-VALUE_BITS){lab_q[VALUE_BITS-1]}}, lab_q}
                      <<< lrgd_pkg::Q_FRAC) - lrgd_pkg::ext_w(hyp_q));
    assign prod_sat = lrgd_pkg::sat_w({mrsp.p[lrgd_pkg::PROD_BITS-1], mrsp.p});
    assign step_ext = {{(PB-SB){mrsp.p[lrgd_pkg::PROD_BITS-1]}},
                       mrsp.p[lrgd_pkg::PROD_BITS-1:lrgd_pkg::ALPHA_BITS]};

    lrgd_ram #(.WIDTH(VALUE_BITS), .DEPTH(FDEPTH), .AW(FAW)) u_feat (
        .i_clk(i_clk), .i_we(feat_we), .i_waddr(feat_waddr), .i_wdata(v),
        .i_re(feat_re), .i_raddr(r_addr), .o_rdata(feat_q)
    );

    lrgd_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_SAMPLES), .AW(SAW)) u_label (
        .i_clk(i_clk), .i_we(lab_we), .i_waddr(r_cnt[SAW-1:0]), .i_wdata(v),
        .i_re(samp_re), .i_raddr(r_j[SAW-1:0]), .o_rdata(lab_q)
    );

    lrgd_ram #(.WIDTH(WIW), .DEPTH(MAX_SAMPLES), .AW(SAW)) u_fill (
        .i_clk(i_clk), .i_we(lab_we), .i_waddr(r_cnt[SAW-1:0]), .i_wdata(r_pos),
        .i_re(fill_re), .i_raddr(r_j[SAW-1:0]), .o_rdata(fill_q)
    );

    lrgd_ram #(.WIDTH(WB), .DEPTH(MAX_SAMPLES), .AW(SAW)) u_hyp (
        .i_clk(i_clk), .i_we(hyp_we), .i_waddr(r_j[SAW-1:0]), .i_wdata(r_acc),
        .i_re(samp_re), .i_raddr(r_j[SAW-1:0]), .o_rdata(hyp_q)
    );

    lrgd_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_mreq), .o_rsp(mrsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_fc <= lrgd_pkg::FC_RESET;
            r_cfg_it <= lrgd_pkg::ITER_RESET;
            r_cfg_lr <= lrgd_pkg::LR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lrgd_pkg::CFG_FEATURE_COUNT: begin
                    r_cfg_fc <= i_cfg_data[lrgd_pkg::FC_BITS-1:0];
                end
                lrgd_pkg::CFG_ITERATION_COUNT: begin
                    r_cfg_it <= i_cfg_data[lrgd_pkg::ITER_BITS-1:0];
                end
                lrgd_pkg::CFG_LEARNING_RATE: begin
                    r_cfg_lr <= i_cfg_data[lrgd_pkg::ALPHA_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_cnt        <= '0;
            r_pos        <= '0;
            r_base       <= '0;
            r_ovalid     <= 1'b0;
            r_mreq.start <= 1'b0;
        end else begin
            r_mreq.start <= (r_state == ST_H_RD) || (r_state == ST_G_RD) ||
                            ((r_state == ST_G_J) && (r_j == r_cnt));
            case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        if (is_feat) begin
                            r_pos <= r_pos + 1'b1;
                        end else begin
                            r_pos <= '0;
                            if (room) begin
                                r_cnt <= r_cnt + 1'b1;
                            end
                            if (room && !i_sample.end_of_set) begin
                                r_base <= r_base + FAW'(MAX_FEATURES);
                            end
                            if (i_sample.end_of_set) begin
                                r_fc   <= fc_now;
                                r_iter <= '0;
                                r_base <= '0;
                                r_j    <= '0;
                                r_k    <= '0;
                                for (int i = 0; i <= MAX_FEATURES; i++) begin
                                    r_w[i] <= lrgd_pkg::W_ONE;
                                end
                                if (r_cfg_it == '0) begin
                                    r_ovalid  <= 1'b1;
                                    r_oweight <= lrgd_pkg::W_ONE;
                                    r_olast   <= (fc_now == '0);
                                    r_state   <= ST_EMIT;
                                end else begin
                                    r_state <= ST_H_J;
                                end
                            end
                        end
                    end
                end
                ST_H_J: begin
                    if (r_j == r_cnt) begin
                        r_k     <= '0;
                        r_state <= ST_G_K;
                    end else begin
                        r_acc   <= r_w[0];
                        r_k     <= KW'(1);
                        r_addr  <= r_base;
                        r_state <= ST_H_K;
                    end
                end
                ST_H_K: begin
                    if (k_over) begin
                        r_j     <= r_j + 1'b1;
                        r_base  <= r_base + FAW'(MAX_FEATURES);
                        r_state <= ST_H_J;
                    end else begin
                        r_state <= ST_H_RD;
                    end
                end
                ST_H_RD: begin
                    r_mreq.a     <= w_k;
                    r_mreq.b     <= {{(MB-VALUE_BITS){x_feat[VALUE_BITS-1]}}, x_feat};
                    r_state      <= ST_H_MUL;
                end
                ST_H_MUL: begin
                    if (mrsp.done) begin
                        r_acc   <= lrgd_pkg::sat_w(lrgd_pkg::ext_w(r_acc)
                                   + lrgd_pkg::ext_w(prod_sat));
                        r_k     <= r_k + 1'b1;
                        r_addr  <= r_addr + 1'b1;
                        r_state <= ST_H_K;
                    end
                end
                ST_G_K: begin
                    if (k_over) begin
                        r_iter <= r_iter + 1'b1;
                        if (r_iter == r_cfg_it - 1'b1) begin
                            r_k       <= '0;
                            r_ovalid  <= 1'b1;
                            r_oweight <= r_w[0];
                            r_olast   <= (r_fc == '0);
                            r_state   <= ST_EMIT;
                        end else begin
                            r_j     <= '0;
                            r_base  <= '0;
                            r_state <= ST_H_J;
                        end
                    end else begin
                        r_g     <= '0;
                        r_j     <= '0;
                        r_addr  <= (r_k == '0) ? '0 : FAW'(r_k - 1'b1);
                        r_state <= ST_G_J;
                    end
                end
                ST_G_J: begin
                    if (r_j == r_cnt) begin
                        r_mreq.a     <= r_g;
                        r_mreq.b     <= {1'b0, r_cfg_lr};
                        r_state      <= ST_G_STEP;
                    end else begin
                        r_state <= ST_G_RD;
                    end
                end
                ST_G_RD: begin
                    r_mreq.a     <= err;
                    if (r_k == '0) begin
                        r_mreq.b <= MB'(1);
                    end else begin
                        r_mreq.b <= {{(MB-VALUE_BITS){x_feat[VALUE_BITS-1]}}, x_feat};
                    end
                    r_state <= ST_G_MUL;
                end
                ST_G_MUL: begin
                    if (mrsp.done) begin
                        r_g     <= lrgd_pkg::sat_w(lrgd_pkg::ext_w(r_g)
                                   + lrgd_pkg::ext_w(prod_sat));
                        r_j     <= r_j + 1'b1;
                        r_addr  <= r_addr + FAW'(MAX_FEATURES);
                        r_state <= ST_G_J;
                    end
                end
                ST_G_STEP: begin
                    if (mrsp.done) begin
                        r_w[r_k[WIW-1:0]] <= lrgd_pkg::sat_w(lrgd_pkg::ext_w(w_k) + step_ext);
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_G_K;
                    end
                end
                ST_EMIT: begin
                    if (out_acc) begin
                        if (r_olast) begin
                            r_ovalid <= 1'b0;
                            r_cnt    <= '0;
                            r_base   <= '0;
                            r_state  <= ST_LOAD;
                        end else begin
                            r_k       <= r_k + 1'b1;
                            r_oweight <= r_w[WIW'(r_k + 1'b1)];
                            r_olast   <= (r_k + 1'b1) == KW'(r_fc);
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign i_sample.ready        = (r_state == ST_LOAD);
    assign o_weight.valid        = r_ovalid;
    assign o_weight.weight       = r_oweight;
    assign o_weight.weight_index = lrgd_pkg::IDX_BITS'(r_k);
    assign o_weight.last         = r_olast;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_sample.ready && o_weight.valid))
        else $error("input ready while a weight word is pending");

    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_weight.valid && o_weight.ready && o_weight.last) |=> i_sample.ready)
        else $error("loading did not resume after the last weight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= SCW'(MAX_SAMPLES))
        else $error("sample count beyond store depth");
endmodule

[design/lrgd_ram.sv]
// Simple dual-port RAM with registered read data.
// Depends on nothing else.
module lrgd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/lrgd_mul.sv]
// Serial shift-add multiplier, one multiplier bit per cycle, exact signed product.
// Depends on lrgd_pkg for widths and the request and response structs.
module lrgd_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lrgd_pkg::t_mul_req i_req,
    output lrgd_pkg::t_mul_rsp o_rsp
);
    localparam int MW = lrgd_pkg::PROD_BITS - 1;

    logic [lrgd_pkg::W_BITS-1:0]  a_mag;
    logic [lrgd_pkg::MB_BITS-1:0] b_mag;
    logic [MW-1:0]                r_ma;
    logic [lrgd_pkg::MB_BITS-1:0] r_mb;
    logic [MW-1:0]                r_acc;
    logic                         r_neg;
    logic                         r_busy;
    logic                         r_done;
    logic signed [lrgd_pkg::PROD_BITS-1:0] r_p;

    assign a_mag = i_req.a[lrgd_pkg::W_BITS-1] ? (~i_req.a + 1'b1) : i_req.a;
    assign b_mag = i_req.b[lrgd_pkg::MB_BITS-1] ? (~i_req.b + 1'b1) : i_req.b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_done <= 1'b0;
                r_ma   <= MW'(a_mag);
                r_mb   <= b_mag;
                r_acc  <= '0;
                r_neg  <= i_req.a[lrgd_pkg::W_BITS-1] ^ i_req.b[lrgd_pkg::MB_BITS-1];
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_mb == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_p    <= r_neg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});
                end else begin
                    r_done <= 1'b0;
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb >> 1;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;
endmodule

[verif/tb_linear_regression_gradient_descent_unit.sv]
// Testbench for linear_regression_gradient_descent_unit: directed table, then random sets.
// Depends on lrgd_pkg, lrgd_sample_if, lrgd_weight_if and the unit itself.
// Weights are checked against a fixed-point training predictor held here.
module tb_linear_regression_gradient_descent_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSAMP = lrgd_pkg::MAX_SAMPLES_DEF;
    localparam int NFEAT = lrgd_pkg::MAX_FEATURES_DEF;
    localparam int WB    = lrgd_pkg::W_BITS;

    typedef logic signed [127:0] t_wide;
    typedef enum bit {ROW_CFG, ROW_WORD} t_row_kind;
    typedef struct {
        t_row_kind                          kind;
        logic [lrgd_pkg::CFG_IDX_BITS-1:0]  idx;
        logic [lrgd_pkg::CFG_DATA_BITS-1:0] data;
        logic signed [15:0]                 val;
        bit                                 eos;
        bit                                 pin;
    } t_row;
    typedef struct {
        logic [WB-1:0] weight;
        logic [3:0]    index;
        bit            last;
    } t_weight_word;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [lrgd_pkg::CFG_IDX_BITS-1:0] i_cfg_index;
    logic [lrgd_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    lrgd_sample_if #(.VALUE_BITS(lrgd_pkg::VALUE_BITS_DEF)) smp();
    lrgd_weight_if wgt();

    linear_regression_gradient_descent_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sample(smp), .o_weight(wgt),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state.
    logic [3:0]  m_fc;
    logic [15:0] m_iters;
    logic [31:0] m_alpha;
    int          m_feat[NSAMP*NFEAT];
    int          m_label[NSAMP];
    logic signed [WB-1:0] m_hyp[NSAMP];
    logic signed [WB-1:0] m_w[NFEAT+1];
    int          m_count;
    int          m_pos;
    bit          pin_ones;

    t_weight_word weights_due[$];
    int  errors = 0;
    bit  idle_on = 1'b1;
    bit  long_hold = 1'b0;
    int  words_sent = 0;

    function automatic logic signed [WB-1:0] clamp_q(t_wide v);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< 47) - 1;
        lo = -(t_wide'(1) <<< 47);
        if (v > hi) return hi[WB-1:0];
        if (v < lo) return lo[WB-1:0];
        return v[WB-1:0];
    endfunction

    function automatic logic signed [WB-1:0] mul_q(t_wide a, t_wide b);
        return clamp_q(a * b);
    endfunction

    task automatic run_training(int fc);
        t_wide acc, err, grad, step, lr, wk, xk;
        for (int k = 0; k <= fc; k++) m_w[k] = lrgd_pkg::W_ONE;
        lr = {96'b0, m_alpha};
        for (int it = 0; it < m_iters; it++) begin
            for (int j = 0; j < m_count; j++) begin
                acc = m_w[0];
                for (int k = 1; k <= fc; k++) begin
                    wk = m_w[k];
                    xk = m_feat[j*NFEAT+k-1];
                    acc = clamp_q(acc + t_wide'(mul_q(wk, xk)));
                end
                m_hyp[j] = acc[WB-1:0];
            end
            for (int k = 0; k <= fc; k++) begin
                grad = 0;
                for (int j = 0; j < m_count; j++) begin
                    err = t_wide'(m_label[j]) * (t_wide'(1) <<< 24) - t_wide'(m_hyp[j]);
                    err = clamp_q(err);
                    xk = (k == 0) ? t_wide'(1) : t_wide'(m_feat[j*NFEAT+k-1]);
                    grad = clamp_q(grad + t_wide'(mul_q(err, xk)));
                end
                step = (grad * lr) >>> 32;
                wk = m_w[k];
                m_w[k] = clamp_q(wk + step);
            end
        end
    endtask

    task automatic absorb_word(logic signed [15:0] v, bit eos);
        int fc;
        t_weight_word r;
        fc = (m_fc > NFEAT) ? NFEAT : m_fc;
        if (m_pos < fc && !eos) begin
            if (m_count < NSAMP) m_feat[m_count*NFEAT+m_pos] = v;
            m_pos++;
            return;
        end
        if (m_count < NSAMP) begin
            for (int k = m_pos; k < NFEAT; k++) m_feat[m_count*NFEAT+k] = 0;
            m_label[m_count] = v;
            m_count++;
        end
        m_pos = 0;
        if (!eos) return;
        run_training(fc);
        for (int k = 0; k <= fc; k++) begin
            r.weight = pin_ones ? lrgd_pkg::W_ONE : m_w[k];
            r.index = 4'(k);
            r.last = (k == fc);
            weights_due.insert(weights_due.size(), r);
        end
        m_count = 0;
    endtask

    task automatic write_reg(logic [lrgd_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [lrgd_pkg::CFG_DATA_BITS-1:0] d);
        smp.valid <= 1'b0;
        while (weights_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lrgd_pkg::CFG_FEATURE_COUNT:   m_fc = d[3:0];
            lrgd_pkg::CFG_ITERATION_COUNT: m_iters = d[15:0];
            lrgd_pkg::CFG_LEARNING_RATE:   m_alpha = d;
            default: ;
        endcase
    endtask

    task automatic send_word(logic signed [15:0] v, bit eos);
        if (idle_on && $urandom_range(3) == 0) begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        smp.value <= v;
        smp.end_of_set <= eos;
        smp.valid <= 1'b1;
        do @(posedge i_clk); while (!smp.ready);
        absorb_word(v, eos);
        words_sent++;
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(3))
            0: return 16'($urandom_range(65535));
            1: return $signed(16'($urandom_range(64))) - 16'sd32;
            default: return $signed(16'($urandom_range(400))) - 16'sd200;
        endcase
    endfunction

    task automatic send_set(int fc, int nsamp, bit hold);
        for (int s = 0; s < nsamp; s++) begin
            for (int k = 0; k < fc; k++) begin
                if (!hold && $urandom_range(40) == 0) begin
                    send_word(pick_value(), 1'b1);
                    return;
                end
                send_word(pick_value(), 1'b0);
            end
            if (s == nsamp - 1 && (hold || $urandom_range(8) == 0)) long_hold = 1'b1;
            send_word(pick_value(), s == nsamp - 1);
        end
    endtask

    t_row table_rows[] = '{
        '{ROW_CFG,  lrgd_pkg::CFG_ITERATION_COUNT, 32'd0, 16'sd0, 1'b0, 1'b0},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, 16'sd32767, 1'b0, 1'b1},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, -16'sd32768, 1'b1, 1'b1},
        '{ROW_CFG,  lrgd_pkg::CFG_ITERATION_COUNT, 32'd2, 16'sd0, 1'b0, 1'b0},
        '{ROW_CFG,  lrgd_pkg::CFG_LEARNING_RATE, 32'hFFFF_FFFF, 16'sd0, 1'b0, 1'b0},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, -16'sd32768, 1'b0, 1'b0},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, 16'sd32767, 1'b0, 1'b0},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, 16'sd32767, 1'b0, 1'b0},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, -16'sd32768, 1'b1, 1'b0},
        '{ROW_CFG,  lrgd_pkg::CFG_FEATURE_COUNT, 32'd3, 16'sd0, 1'b0, 1'b0},
        '{ROW_CFG,  lrgd_pkg::CFG_ITERATION_COUNT, 32'd1, 16'sd0, 1'b0, 1'b0},
        '{ROW_CFG,  lrgd_pkg::CFG_LEARNING_RATE, 32'd0, 16'sd0, 1'b0, 1'b0},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, 16'sd5, 1'b0, 1'b1},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, 16'sd7, 1'b1, 1'b1},
        '{ROW_CFG,  lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, 16'sd0, 1'b0, 1'b0},
        '{ROW_CFG,  lrgd_pkg::CFG_LEARNING_RATE, 32'd42950, 16'sd0, 1'b0, 1'b0},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, 16'sd100, 1'b0, 1'b0},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, -16'sd50, 1'b1, 1'b0},
        '{ROW_CFG,  lrgd_pkg::CFG_FEATURE_COUNT, 32'd15, 16'sd0, 1'b0, 1'b0},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, 16'sd3, 1'b0, 1'b0},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, -16'sd3, 1'b0, 1'b0},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, 16'sd9, 1'b1, 1'b0},
        '{ROW_CFG,  lrgd_pkg::CFG_FEATURE_COUNT, 32'd1, 16'sd0, 1'b0, 1'b0},
        '{ROW_CFG,  lrgd_pkg::CFG_ITERATION_COUNT, 32'd300, 16'sd0, 1'b0, 1'b0},
        '{ROW_CFG,  lrgd_pkg::CFG_LEARNING_RATE, 32'h1000_0000, 16'sd0, 1'b0, 1'b0},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, 16'sd2, 1'b0, 1'b0},
        '{ROW_WORD, lrgd_pkg::CFG_FEATURE_COUNT, 32'd0, 16'sd5, 1'b1, 1'b0}
    };

    initial begin
        int fc;
        bit hold_next;
        bit keep_cfg;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= lrgd_pkg::CFG_FEATURE_COUNT;
        i_cfg_data <= '0;
        smp.valid <= 1'b0;
        smp.value <= '0;
        smp.end_of_set <= 1'b0;
        m_fc = lrgd_pkg::FC_RESET;
        m_iters = lrgd_pkg::ITER_RESET;
        m_alpha = lrgd_pkg::LR_RESET;
        m_count = 0;
        m_pos = 0;
        pin_ones = 1'b0;
        fc = 1;
        hold_next = 1'b1;
        keep_cfg = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i]) begin
            if (table_rows[i].kind == ROW_CFG) begin
                write_reg(table_rows[i].idx, table_rows[i].data);
            end else begin
                pin_ones = table_rows[i].pin;
                send_word(table_rows[i].val, table_rows[i].eos);
                pin_ones = 1'b0;
            end
        end

        // The first random set stalls the receiver while the next set is offered.
        while (words_sent < 420) begin
            if (words_sent > 340) idle_on = 1'b0;
            if (!keep_cfg) begin
                case ($urandom_range(9))
                    0: fc = 0;
                    1: fc = 15;
                    default: fc = $urandom_range(1, 4);
                endcase
                write_reg(lrgd_pkg::CFG_FEATURE_COUNT, 32'(fc));
                write_reg(lrgd_pkg::CFG_ITERATION_COUNT, 32'($urandom_range(4)));
                case ($urandom_range(4))
                    0: write_reg(lrgd_pkg::CFG_LEARNING_RATE, 32'hFFFF_FFFF);
                    1: write_reg(lrgd_pkg::CFG_LEARNING_RATE, $urandom());
                    default: write_reg(lrgd_pkg::CFG_LEARNING_RATE, $urandom_range(2000000));
                endcase
            end
            send_set(fc, (fc > 8) ? $urandom_range(1, 2) : $urandom_range(1, 6), hold_next);
            keep_cfg = hold_next;
            hold_next = 1'b0;
        end
        smp.valid <= 1'b0;

        while (weights_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                wgt.ready <= 1'b0;
                @(posedge i_clk);
                while (!wgt.valid) @(posedge i_clk);
                repeat (300) @(posedge i_clk);
            end else if (idle_on && $urandom_range(4) == 0) begin
                wgt.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                wgt.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_weight_word e;
        if (i_rst_n && wgt.valid && wgt.ready) begin
            if (weights_due.size() == 0) begin
                $display("%0t: unexpected word, actual w=%h idx=%0d last=%0b", $realtime,
                         wgt.weight, wgt.weight_index, wgt.last);
                errors++;
            end else begin
                e = weights_due.pop_front();
                if (wgt.weight !== e.weight || wgt.weight_index !== e.index ||
                    wgt.last !== e.last) begin
                    $display("%0t: expected w=%h idx=%0d last=%0b, actual w=%h idx=%0d last=%0b",
                             $realtime, e.weight, e.index, e.last,
                             wgt.weight, wgt.weight_index, wgt.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule

[linear_regression_gradient_descent_unit.f]
design/lrgd_pkg.sv
design/lrgd_sample_if.sv
design/lrgd_weight_if.sv
design/lrgd_ram.sv
design/lrgd_mul.sv
design/linear_regression_gradient_descent_unit.sv
verif/tb_linear_regression_gradient_descent_unit.sv
